// ===== rtl/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// dip_pkg: shared types and constants of the decimal integer parser
// Target formats, word payloads and the range limits used by the checks.
// ----------------------------------------------------------------------------
package dip_pkg;

  // target type selected by the format register
  typedef enum logic [1:0] {
    FMT_I64 = 2'd0,
    FMT_I32 = 2'd1,
    FMT_U64 = 2'd2,
    FMT_U32 = 2'd3
  } fmt_e;

  // range limits
  localparam logic [63:0] SignedCeil = 64'h8000_0000_0000_0000;
  localparam logic [63:0] I64Top     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I32NegCeil = 64'h0000_0000_8000_0000;
  localparam logic [63:0] I32Top     = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] U32Top     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] U64Top     = 64'hFFFF_FFFF_FFFF_FFFF;

  // digit count limit in the signed formats, counter saturates one above
  localparam int unsigned MaxSignedDigits = 20;
  localparam int unsigned DigitCntW       = 5;

  // character codes
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // input word: one character
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
    logic       empty_string;
  } in_word_t;

  // output word: one parse result
  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } out_word_t;

endpackage

// ===== rtl/dip_in_if.sv =====
// ----------------------------------------------------------------------------
// dip_in_if: character channel
// Valid/ready channel that carries one character word.
// ----------------------------------------------------------------------------
interface dip_in_if;
  logic             valid;
  logic             ready;
  dip_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dip_out_if.sv =====
// ----------------------------------------------------------------------------
// dip_out_if: result channel
// Valid/ready channel that carries one parse result word.
// ----------------------------------------------------------------------------
interface dip_out_if;
  logic              valid;
  logic              ready;
  dip_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/decimal_integer_parser_top.sv =====
// ----------------------------------------------------------------------------
// decimal_integer_parser_top: streaming decimal string to integer parser
// Takes a character per cycle unless a held result stalls; ok+value per string.
// ----------------------------------------------------------------------------
// The parser takes one character word per clock cycle, back to back, and gives
// one result word in the cycle after the last character (or an empty-string
// word) is taken. The rate is set by the running magnitude loop: each
// character does one multiply by ten, one add of the digit and one compare
// against the signed or unsigned limit as one combinational step. The result
// sits in an output register; a new character is taken while that register
// is empty or its word is taken in the same cycle. The format register may
// be written only while no string is in progress and no result is pending.
module decimal_integer_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  dip_in_if.sink     in_i,
  dip_out_if.source  out_o
);

  // format register
  logic [1:0] number_format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_format_q <= 2'(dip_pkg::FMT_I64);
    end else if (cfg_we_i) begin
      number_format_q <= cfg_wdata_i;
    end
  end

  // parse state
  logic [63:0]                     magnitude_q, magnitude_d;
  logic                            negative_q, negative_d;
  logic                            at_start_q, at_start_d;
  logic                            has_digit_q, has_digit_d;
  logic                            failed_q, failed_d;
  logic [dip_pkg::DigitCntW-1:0]   digits_q, digits_d;

  // output register
  logic               out_valid_q, out_valid_d;
  dip_pkg::out_word_t out_word_q, out_word_d;

  logic in_acc;
  logic ends_string;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign ends_string = in_i.data.last_char || in_i.data.empty_string;

  // character step and end-of-string check
  always_comb begin
    dip_pkg::fmt_e fmt;
    logic          signed_mode;
    logic [7:0]    ch;
    logic          is_digit;
    logic [3:0]    digit;
    logic [67:0]   cand;
    logic [63:0]   limit;
    logic          ok;
    logic [63:0]   val;

    fmt         = dip_pkg::fmt_e'(number_format_q);
    signed_mode = (fmt == dip_pkg::FMT_I64) || (fmt == dip_pkg::FMT_I32);
    ch          = in_i.data.char_byte;
    is_digit    = (ch >= dip_pkg::ChZero) && (ch <= dip_pkg::ChNine);
    digit       = 4'(ch - dip_pkg::ChZero);
    // magnitude * 10 + digit, exact in 68 bits
    cand        = {1'b0, magnitude_q, 3'b000} + {3'b000, magnitude_q, 1'b0}
                  + {64'd0, digit};
    limit       = signed_mode ? dip_pkg::SignedCeil : dip_pkg::U64Top;

    magnitude_d = magnitude_q;
    negative_d  = negative_q;
    at_start_d  = at_start_q;
    has_digit_d = has_digit_q;
    failed_d    = failed_q;
    digits_d    = digits_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_word_d  = out_word_q;
    ok          = 1'b0;
    val         = '0;

    if (in_acc) begin
      if (in_i.data.empty_string) begin
        out_valid_d      = 1'b1;
        out_word_d.ok    = 1'b0;
        out_word_d.value = '0;
      end else begin
        // one character
        if (!failed_q) begin
          if (at_start_q && (ch == dip_pkg::ChPlus ||
                             (ch == dip_pkg::ChMinus && signed_mode))) begin
            negative_d = (ch == dip_pkg::ChMinus);
          end else if (is_digit) begin
            if (cand > {4'd0, limit}) begin
              failed_d = 1'b1;
            end else begin
              magnitude_d = cand[63:0];
              has_digit_d = 1'b1;
              if (digits_q < dip_pkg::DigitCntW'(dip_pkg::MaxSignedDigits + 1)) begin
                digits_d = digits_q + 1'b1;
              end
              if (signed_mode &&
                  digits_d > dip_pkg::DigitCntW'(dip_pkg::MaxSignedDigits)) begin
                failed_d = 1'b1;
              end
            end
          end else begin
            failed_d = 1'b1;
          end
        end
        at_start_d = 1'b0;

        // range check at the end of the string
        ok  = !failed_d && has_digit_d;
        val = magnitude_d;
        case (fmt)
          dip_pkg::FMT_I64: begin
            if (negative_d) begin
              ok  = ok && (magnitude_d <= dip_pkg::SignedCeil);
              val = 64'd0 - magnitude_d;
            end else begin
              ok  = ok && (magnitude_d <= dip_pkg::I64Top);
            end
          end
          dip_pkg::FMT_I32: begin
            if (negative_d) begin
              ok  = ok && (magnitude_d <= dip_pkg::I32NegCeil);
              val = 64'd0 - magnitude_d;
            end else begin
              ok  = ok && (magnitude_d <= dip_pkg::I32Top);
            end
          end
          dip_pkg::FMT_U64: begin
            ok = ok && !negative_d;
          end
          default: begin
            ok = ok && !negative_d && (magnitude_d <= dip_pkg::U32Top);
          end
        endcase
        if (in_i.data.last_char) begin
          out_valid_d      = 1'b1;
          out_word_d.ok    = ok;
          out_word_d.value = ok ? val : 64'd0;
        end
      end

      // string done: back to the start state
      if (ends_string) begin
        magnitude_d = '0;
        negative_d  = 1'b0;
        at_start_d  = 1'b1;
        has_digit_d = 1'b0;
        failed_d    = 1'b0;
        digits_d    = '0;
      end
    end
  end

  // state and valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnitude_q <= '0;
      negative_q  <= 1'b0;
      at_start_q  <= 1'b1;
      has_digit_q <= 1'b0;
      failed_q    <= 1'b0;
      digits_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      magnitude_q <= magnitude_d;
      negative_q  <= negative_d;
      at_start_q  <= at_start_d;
      has_digit_q <= has_digit_d;
      failed_q    <= failed_d;
      digits_q    <= digits_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

  // a failed result never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_word_q.ok |-> out_word_q.value == 64'd0)
    else $error("failed result with nonzero value");

  // the end of a string returns the state to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ends_string |=> at_start_q && !failed_q && !has_digit_q
      && magnitude_q == 64'd0 && out_valid_q)
    else $error("state not cleared after end of string");

  // a character that does not end a string gives no new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !ends_string |=> !out_valid_q)
    else $error("result raised without end of string");

  // digit counter saturates one above the signed limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= dip_pkg::DigitCntW'(dip_pkg::MaxSignedDigits + 1))
    else $error("digit counter out of range");

endmodule
